// ===== hw/rtl/kgd_pkg.sv =====
// shared types and constants for the knn graph geodesic distance block
`timescale 1ns / 1ps
package kgd_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PA_W       = 2 * IDX_W;
    localparam int PM_DEPTH   = MAX_POINTS * MAX_POINTS;

    localparam int COORD_W    = 16;
    localparam int PT_W       = 3 * COORD_W;
    localparam int IDX_IN_W   = 6;
    localparam int PC_W       = 7;
    localparam int NB_W       = 6;
    localparam int WIDE_W     = (CNT_W > PC_W) ? CNT_W : PC_W;

    localparam int DIST_W     = 23;
    localparam int PM_W       = DIST_W + 1;
    localparam int SQ_W       = 2 * COORD_W + 2;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int STEP_W     = $clog2(ROOT_W + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [PM_W-1:0] DIST_MAX = {1'b0, {DIST_W{1'b1}}};
    localparam logic [PM_W-1:0] UNREACH  = {1'b1, {DIST_W{1'b0}}};

    localparam logic [PC_W-1:0] PC_RESET = PC_W'(64);
    localparam logic [NB_W-1:0] NB_RESET = NB_W'(10);

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic {
        REG_POINT_COUNT = 1'b0,
        REG_NEIGHBOURS  = 1'b1
    } reg_sel_t;

    typedef struct packed {
        kind_t                kind;
        logic [PT_W-1:0]      point;
        logic [IDX_IN_W-1:0]  hi;
        logic [IDX_IN_W-1:0]  lo;
    } cmd_t;

    typedef struct packed {
        logic [PC_W-1:0] point_count;
        logic [NB_W-1:0] neighbours;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_QWAIT,
        ST_PROW,
        ST_PROW_W,
        ST_PCOL,
        ST_PCOL_W,
        ST_SQUARE,
        ST_ROOT,
        ST_ROOT_W,
        ST_SEL_J,
        ST_SEL_JW,
        ST_SEL_M,
        ST_SEL_MW,
        ST_SEL_WR,
        ST_FW_K,
        ST_FW_KW,
        ST_FW_J,
        ST_FW_JW
    } back_state_t;

endpackage

// ===== hw/rtl/knn_graph_geodesic_distances.sv =====
// top level: register port, front, command queue and back end
//
// channel   dir  handshake                 content
// s_        in   s_tvalid / s_tready       tuser cmd, tdata coords and query indices
// m_        out  m_tvalid / m_tready       tdata geodesic, tuser flags
// apb       in   psel & penable & pwrite   point_count at 0x0, neighbours at 0x4
//
// the load that completes a set starts a sweep that works out the distances (17-step
// serial root), ranks neighbours over the row buffer, and finds the shortest paths
// with a registered ram read. a query that is not ready or out of range is answered
// from idle; any other query reads the path ram in a wait state before it answers.
// reset is synchronous; the queue lets inputs be taken while the back end is busy
// or its result word waits on m_tready.
`timescale 1ns / 1ps
module knn_graph_geodesic_distances (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // coord_x, coord_y, coord_z, row_index, col_index, zero pad
    input  logic        s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // geodesic, zero pad
    output logic [1:0]  m_tuser,  // unreachable, not_ready
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kgd_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [NB_W-1:0] nb_reg, nb_next;
    reg_sel_t        sel;
    cfg_t            cfg;
    logic            q_full, q_push, q_pop, q_valid;
    cmd_t            q_in, q_out;

    always_comb begin
        sel     = reg_sel_t'(paddr[2]);
        pc_next = pc_reg;
        nb_next = nb_reg;
        if (psel && penable && pwrite) begin
            unique case (sel)
                REG_POINT_COUNT: pc_next = pwdata[PC_W-1:0];
                REG_NEIGHBOURS:  nb_next = pwdata[NB_W-1:0];
                default:         pc_next = pc_reg;
            endcase
        end
        unique case (sel)
            REG_POINT_COUNT: prdata = 32'(pc_reg);
            REG_NEIGHBOURS:  prdata = 32'(nb_reg);
            default:         prdata = '0;
        endcase
        cfg.point_count = pc_reg;
        cfg.neighbours  = nb_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_RESET;
            nb_reg <= NB_RESET;
        end else begin
            pc_reg <= pc_next;
            nb_reg <= nb_next;
        end
    end

    assign pready = 1'b1;

    kgd_front u_front (
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_full(q_full), .q_push(q_push), .q_data(q_in)
    );

    kgd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .valid(q_valid), .pop_data(q_out)
    );

    kgd_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg), .q_valid(q_valid), .q_data(q_out),
        .q_pop(q_pop), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );
endmodule

// ===== hw/rtl/kgd_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module kgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/kgd_isqrt.sv =====
// iterative floor square root, one result bit per cycle
`timescale 1ns / 1ps
module kgd_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [kgd_pkg::SQ_W-1:0]    radicand,
    output logic                        done,
    output logic [kgd_pkg::ROOT_W-1:0]  root
);
    import kgd_pkg::*;

    logic [SQ_W-1:0]   rad_reg, rad_next;
    logic [ROOT_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (busy_reg) begin
            rad_next = {rad_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = ROOT_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = ROOT_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== hw/rtl/kgd_fifo.sv =====
// short command queue between front and back
`timescale 1ns / 1ps
module kgd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  kgd_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output kgd_pkg::cmd_t pop_data
);
    import kgd_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg, wptr_next;
    logic [FIFO_AW-1:0] rptr_reg, rptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;

    always_comb begin
        wptr_next = wptr_reg + FIFO_AW'(push);
        rptr_next = rptr_reg + FIFO_AW'(pop);
        cnt_next  = cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    assign full     = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = mem_reg[rptr_reg];

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid |-> !pop) else $error("queue underflow");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count slip");
endmodule

// ===== hw/rtl/kgd_front.sv =====
// input side: accepts words, classifies them and orders query indices
`timescale 1ns / 1ps
module kgd_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,
    input  logic          s_tuser,
    input  logic          q_full,
    output logic          q_push,
    output kgd_pkg::cmd_t q_data
);
    import kgd_pkg::*;

    logic [IDX_IN_W-1:0] row;
    logic [IDX_IN_W-1:0] col;

    always_comb begin
        row           = s_tdata[PT_W +: IDX_IN_W];
        col           = s_tdata[PT_W+IDX_IN_W +: IDX_IN_W];
        q_data.kind   = kind_t'(s_tuser);
        q_data.point  = s_tdata[PT_W-1:0];
        q_data.hi     = (row > col) ? row : col;
        q_data.lo     = (row > col) ? col : row;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
endmodule

// ===== hw/rtl/kgd_back.sv =====
// back end: point store, distance and neighbour pass, shortest path sweep, queries
`timescale 1ns / 1ps
module kgd_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  kgd_pkg::cfg_t             cfg,
    input  logic                      q_valid,
    input  kgd_pkg::cmd_t             q_data,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,
    output logic [1:0]                m_tuser
);
    import kgd_pkg::*;

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   loaded_reg, loaded_next;
    logic               ready_reg, ready_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [WIDE_W-1:0]  keep_reg, keep_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   m_reg, m_next;
    logic [CNT_W-1:0]   rank_reg, rank_next;
    logic [1:0]         axis_reg, axis_next;
    logic [SQ_W-1:0]    acc_reg, acc_next;
    logic [PT_W-1:0]    pi_reg, pi_next;
    logic [PT_W-1:0]    pj_reg, pj_next;
    logic [DIST_W-1:0]  dj_reg, dj_next;
    logic [PM_W-1:0]    pik_reg, pik_next;

    logic               ov_reg, ov_next;
    logic [DIST_W-1:0]  og_reg, og_next;
    logic               ou_reg, ou_next;
    logic               onr_reg, onr_next;

    logic               pt_we;
    logic [IDX_W-1:0]   pt_waddr, pt_raddr;
    logic [PT_W-1:0]    pt_rdata;
    logic               dr_we;
    logic [IDX_W-1:0]   dr_raddr;
    logic [DIST_W-1:0]  dr_rdata;
    logic               pm_we;
    logic [PA_W-1:0]    pm_waddr, pm_raddr_a, pm_raddr_b;
    logic [PM_W-1:0]    pm_wdata, pm_rdata_a, pm_rdata_b;
    logic               sq_start, sq_done;
    logic [ROOT_W-1:0]  sq_root;

    logic [CNT_W-1:0]   n_eff;
    logic [WIDE_W-1:0]  pc_w;
    logic [WIDE_W-1:0]  nb_plus;
    logic [CNT_W-1:0]   load_idx;
    logic [WIDE_W-1:0]  hi_w;
    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0] adiff;
    logic [2*COORD_W-1:0] sq;
    logic [PM_W-1:0]    sum;
    logic [PM_W-1:0]    cand;

    kgd_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_points (
        .aclk(aclk), .we(pt_we), .waddr(pt_waddr), .wdata(q_data.point),
        .raddr(pt_raddr), .rdata(pt_rdata)
    );

    kgd_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_row_dist (
        .aclk(aclk), .we(dr_we), .waddr(j_reg[IDX_W-1:0]),
        .wdata(DIST_W'(sq_root)), .raddr(dr_raddr), .rdata(dr_rdata)
    );

    kgd_ram #(.WIDTH(PM_W), .DEPTH(PM_DEPTH)) u_path_a (
        .aclk(aclk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr_a), .rdata(pm_rdata_a)
    );

    kgd_ram #(.WIDTH(PM_W), .DEPTH(PM_DEPTH)) u_path_b (
        .aclk(aclk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr_b), .rdata(pm_rdata_b)
    );

    kgd_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .radicand(acc_reg),
        .done(sq_done), .root(sq_root)
    );

    always_comb begin
        pc_w = WIDE_W'(cfg.point_count);
        if (pc_w < WIDE_W'(2)) begin
            n_eff = CNT_W'(2);
        end else if (pc_w > WIDE_W'(MAX_POINTS)) begin
            n_eff = CNT_W'(MAX_POINTS);
        end else begin
            n_eff = CNT_W'(pc_w);
        end
        nb_plus  = WIDE_W'(cfg.neighbours) + 1'b1;
        load_idx = (ready_reg || loaded_reg >= n_eff) ? '0 : loaded_reg;
        hi_w     = WIDE_W'(q_data.hi);

        diff  = $signed({pi_reg[axis_reg*COORD_W + COORD_W - 1], pi_reg[axis_reg*COORD_W +: COORD_W]})
              - $signed({pj_reg[axis_reg*COORD_W + COORD_W - 1], pj_reg[axis_reg*COORD_W +: COORD_W]});
        adiff = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
        sq    = adiff * adiff;

        sum  = pik_reg + pm_rdata_a;
        if (pik_reg[PM_W-1] || pm_rdata_a[PM_W-1]) begin
            cand = UNREACH;
        end else if (sum > DIST_MAX) begin
            cand = DIST_MAX;
        end else begin
            cand = sum;
        end
    end

    always_comb begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        ready_next  = ready_reg;
        used_next   = used_reg;
        n_next      = n_reg;
        keep_next   = keep_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        m_next      = m_reg;
        rank_next   = rank_reg;
        axis_next   = axis_reg;
        acc_next    = acc_reg;
        pi_next     = pi_reg;
        pj_next     = pj_reg;
        dj_next     = dj_reg;
        pik_next    = pik_reg;
        ov_next     = ov_reg && !m_tready;
        og_next     = og_reg;
        ou_next     = ou_reg;
        onr_next    = onr_reg;
        q_pop       = 1'b0;
        pt_we       = 1'b0;
        pt_waddr    = load_idx[IDX_W-1:0];
        pt_raddr    = j_reg[IDX_W-1:0];
        dr_we       = 1'b0;
        dr_raddr    = j_reg[IDX_W-1:0];
        pm_we       = 1'b0;
        pm_waddr    = {i_reg[IDX_W-1:0], j_reg[IDX_W-1:0]};
        pm_wdata    = cand;
        pm_raddr_a  = {k_reg[IDX_W-1:0], j_reg[IDX_W-1:0]};
        pm_raddr_b  = {i_reg[IDX_W-1:0], j_reg[IDX_W-1:0]};
        sq_start    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_data.kind == KIND_LOAD) begin
                    q_pop       = 1'b1;
                    pt_we       = 1'b1;
                    ready_next  = 1'b0;
                    loaded_next = load_idx + 1'b1;
                    if (load_idx + 1'b1 == n_eff) begin
                        n_next     = n_eff;
                        keep_next  = (nb_plus > WIDE_W'(n_eff)) ? WIDE_W'(n_eff) : nb_plus;
                        i_next     = '0;
                        state_next = ST_PROW;
                    end
                end else if (q_valid && !ov_reg) begin
                    q_pop      = 1'b1;
                    pm_raddr_a = {hi_w[IDX_W-1:0], q_data.lo[IDX_W-1:0]};
                    if (!ready_reg) begin
                        ov_next  = 1'b1;
                        og_next  = '0;
                        ou_next  = 1'b0;
                        onr_next = 1'b1;
                    end else if (hi_w >= WIDE_W'(used_reg)) begin
                        ov_next  = 1'b1;
                        og_next  = '0;
                        ou_next  = 1'b1;
                        onr_next = 1'b0;
                    end else begin
                        state_next = ST_QWAIT;
                    end
                end
            end
            ST_QWAIT: begin
                ov_next    = 1'b1;
                onr_next   = 1'b0;
                ou_next    = pm_rdata_a[PM_W-1];
                og_next    = pm_rdata_a[PM_W-1] ? '0 : pm_rdata_a[DIST_W-1:0];
                state_next = ST_IDLE;
            end
            ST_PROW: begin
                pt_raddr   = i_reg[IDX_W-1:0];
                state_next = ST_PROW_W;
            end
            ST_PROW_W: begin
                pi_next    = pt_rdata;
                j_next     = '0;
                state_next = ST_PCOL;
            end
            ST_PCOL: begin
                state_next = ST_PCOL_W;
            end
            ST_PCOL_W: begin
                pj_next    = pt_rdata;
                axis_next  = '0;
                acc_next   = '0;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                acc_next  = acc_reg + SQ_W'(sq);
                axis_next = axis_reg + 1'b1;
                if (axis_reg == 2'd2) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                sq_start   = 1'b1;
                state_next = ST_ROOT_W;
            end
            ST_ROOT_W: begin
                if (sq_done) begin
                    dr_we = 1'b1;
                    if (j_reg + 1'b1 == n_reg) begin
                        j_next     = '0;
                        state_next = ST_SEL_J;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_PCOL;
                    end
                end
            end
            ST_SEL_J: begin
                state_next = ST_SEL_JW;
            end
            ST_SEL_JW: begin
                dj_next    = dr_rdata;
                m_next     = '0;
                rank_next  = '0;
                state_next = ST_SEL_M;
            end
            ST_SEL_M: begin
                dr_raddr   = m_reg[IDX_W-1:0];
                state_next = ST_SEL_MW;
            end
            ST_SEL_MW: begin
                if (dr_rdata < dj_reg || (dr_rdata == dj_reg && m_reg < j_reg)) begin
                    rank_next = rank_reg + 1'b1;
                end
                m_next     = m_reg + 1'b1;
                state_next = (m_reg + 1'b1 == n_reg) ? ST_SEL_WR : ST_SEL_M;
            end
            ST_SEL_WR: begin
                pm_we    = 1'b1;
                pm_wdata = (WIDE_W'(rank_reg) < keep_reg) ? {1'b0, dj_reg} : UNREACH;
                if (j_reg + 1'b1 == n_reg) begin
                    j_next = '0;
                    if (i_reg + 1'b1 == n_reg) begin
                        i_next     = '0;
                        k_next     = '0;
                        state_next = ST_FW_K;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_PROW;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SEL_J;
                end
            end
            ST_FW_K: begin
                pm_raddr_b = {i_reg[IDX_W-1:0], k_reg[IDX_W-1:0]};
                state_next = ST_FW_KW;
            end
            ST_FW_KW: begin
                pik_next   = pm_rdata_b;
                j_next     = '0;
                state_next = ST_FW_J;
            end
            ST_FW_J: begin
                state_next = ST_FW_JW;
            end
            ST_FW_JW: begin
                pm_we = (cand < pm_rdata_b);
                if (j_reg + 1'b1 == n_reg) begin
                    j_next = '0;
                    if (i_reg + 1'b1 == n_reg) begin
                        i_next = '0;
                        if (k_reg + 1'b1 == n_reg) begin
                            used_next  = n_reg;
                            ready_next = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_FW_K;
                        end
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_FW_K;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_FW_J;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            loaded_reg <= '0;
            ready_reg  <= 1'b0;
            used_reg   <= '0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            ready_reg  <= ready_next;
            used_reg   <= used_next;
            ov_reg     <= ov_next;
        end
        n_reg    <= n_next;
        keep_reg <= keep_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        m_reg    <= m_next;
        rank_reg <= rank_next;
        axis_reg <= axis_next;
        acc_reg  <= acc_next;
        pi_reg   <= pi_next;
        pj_reg   <= pj_next;
        dj_reg   <= dj_next;
        pik_reg  <= pik_next;
        og_reg   <= og_next;
        ou_reg   <= ou_next;
        onr_reg  <= onr_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, og_reg};
    assign m_tuser  = {onr_reg, ou_reg};

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE) else $error("pop outside idle");
    a_ready_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> used_reg >= CNT_W'(2)) else $error("ready without a valid count");
    a_flag_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && (onr_reg || ou_reg)) |-> og_reg == '0 && !(onr_reg && ou_reg))
        else $error("flagged result carries a length");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !m_tready) |=> ov_reg && $stable(og_reg)) else $error("result dropped");
endmodule
